FILE: rtl/core/rhpm_pkg.sv
// ----------------------------------------------------------------------------
// rhpm_pkg
// Shared types, constants and the symbol mapping for the rolling hash matcher.
// ----------------------------------------------------------------------------
package rhpm_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int POS_W       = 16;
  localparam int SYM_W       = 8;
  localparam int HASH_W      = 20;

  // hash modulus 1e6+3, base 37, and 2^20 mod 1e6+3 for folding
  localparam logic [HASH_W-1:0] HASH_MOD  = 20'd1000003;
  localparam logic [SYM_W-1:0]  HASH_BASE = 8'd37;
  localparam logic [15:0]       FOLD_K    = 16'd48573;

  localparam logic [SYM_W-1:0] CHR_A      = 8'h61;
  localparam logic [SYM_W-1:0] CHR_Z      = 8'h7A;
  localparam logic [SYM_W-1:0] CHR_0      = 8'h30;
  localparam logic [SYM_W-1:0] CHR_9      = 8'h39;
  localparam logic [SYM_W-1:0] DIGIT_BASE = 8'd26;

  localparam logic REQ_PATTERN = 1'b0;
  localparam logic REQ_TEXT    = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } rhpm_in_t;

  typedef struct packed {
    logic [POS_W-1:0] window_end;
    logic             window_full;
    logic             hash_hit;
    logic             match;
    logic             found;
    logic             done_res;
  } rhpm_out_t;

  typedef struct packed {
    logic pat_shift;
    logic pat_clear;
    logic win_shift;
  } rhpm_cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_PAT,
    S_PAT_LEAD,
    S_PAT_HASH,
    S_TXT_SUB,
    S_TXT_HASH,
    S_CMP
  } rhpm_state_t;

  // letters -> 0..25, digits -> 26..35, anything else keeps its code
  function automatic logic [SYM_W-1:0] sym_value(input logic [SYM_W-1:0] b);
    logic [SYM_W-1:0] v;
    if (b >= CHR_A && b <= CHR_Z) begin
      v = b - CHR_A;
    end else if (b >= CHR_0 && b <= CHR_9) begin
      v = b - CHR_0 + DIGIT_BASE;
    end else begin
      v = b;
    end
    return v;
  endfunction

endpackage

FILE: rtl/core/rolling_hash_pattern_matcher.sv
// Sequence: input stalls until the sequencer is back in S_IDLE. A text word
//   passes S_PREP, then the mulmod unit once while the window fills or twice
//   once it is full (none with no pattern), then S_CMP registers its result.
//   Pattern words use the mulmod unit once (first) or twice, none past depth.
// Reset: synchronous active-low rst_n clears the sequencer, pattern and text
//   state; pattern and window bytes are only read after being written.
// ----------------------------------------------------------------------------
// rolling_hash_pattern_matcher
// Streaming Rabin-Karp matcher. Pattern and window bytes live in a chain of
// cells; the hashes run through one shared multiply-mod unit.
// ----------------------------------------------------------------------------
module rolling_hash_pattern_matcher (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rhpm_pkg::rhpm_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rhpm_pkg::rhpm_out_t out_data
);
  import rhpm_pkg::*;

  // sequencer and datapath registers
  rhpm_state_t       state_r, state_nxt;
  rhpm_in_t          item_r, item_nxt;
  logic [LEN_W-1:0]  pat_len_r, pat_len_nxt;
  logic              pat_done_r, pat_done_nxt;
  logic [HASH_W-1:0] pat_hash_r, pat_hash_nxt;
  logic [HASH_W-1:0] lead_r, lead_nxt;       // 37^(L-1) mod M
  logic [HASH_W-1:0] win_hash_r, win_hash_nxt;
  logic [POS_W-1:0]  text_cnt_r, text_cnt_nxt;
  logic              found_r, found_nxt;
  logic [LEN_W-1:0]  fill_r, fill_nxt;       // symbols in window, up to L
  logic              full_r, full_nxt;
  logic [POS_W-1:0]  end_r, end_nxt;
  logic [SYM_W-1:0]  v_r, v_nxt;             // mapped value of the new text symbol
  logic              out_valid_r, out_valid_nxt;
  rhpm_out_t         out_r, out_nxt;

  // mulmod unit
  logic              mm_start;
  logic [20:0]       mm_x;
  logic [7:0]        mm_y;
  logic [7:0]        mm_c;
  logic              mm_done;
  logic [HASH_W-1:0] mm_res;

  // cell chain
  rhpm_cell_ctrl_t   cell_ctrl;
  logic [SYM_W-1:0]  pat_byte_c [PATTERN_MAX];
  logic              pat_v_c    [PATTERN_MAX];
  logic [SYM_W-1:0]  win_byte_c [PATTERN_MAX];
  logic [SYM_W-1:0]  tail_c     [PATTERN_MAX];
  logic              eq_c       [PATTERN_MAX];
  logic [SYM_W-1:0]  tail_any;
  logic              all_eq;

  logic              out_free;
  logic              hit_w;
  logic              match_w;
  logic              found_w;

  // --------------------------------------------------------------------------
  // Chain: cell 0 takes the newest byte. Cell j holds pattern[L-1-j] and the
  // text byte from j words ago, so each cell compares locally.
  // --------------------------------------------------------------------------
  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    logic [SYM_W-1:0] pat_in;
    logic             pv_in;
    logic [SYM_W-1:0] win_in;
    logic             nxt_v;

    if (j == 0) begin : g_head
      assign pat_in = item_r.symbol;
      assign pv_in  = 1'b1;
      assign win_in = item_r.symbol;
    end else begin : g_body
      assign pat_in = pat_byte_c[j-1];
      assign pv_in  = pat_v_c[j-1];
      assign win_in = win_byte_c[j-1];
    end

    if (j == PATTERN_MAX - 1) begin : g_end
      assign nxt_v = 1'b0;
    end else begin : g_mid
      assign nxt_v = pat_v_c[j+1];
    end

    rhpm_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (cell_ctrl),
      .pat_byte_in (pat_in),
      .pat_v_in    (pv_in),
      .win_byte_in (win_in),
      .next_pat_v  (nxt_v),
      .pat_byte_o  (pat_byte_c[j]),
      .pat_v_o     (pat_v_c[j]),
      .win_byte_o  (win_byte_c[j]),
      .tail_byte   (tail_c[j]),
      .eq          (eq_c[j])
    );
  end

  // tail is one-hot, so an OR picks the departing byte
  always_comb begin
    tail_any = '0;
    all_eq   = 1'b1;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      tail_any = tail_any | tail_c[j];
      all_eq   = all_eq & eq_c[j];
    end
  end

  rhpm_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mm_start),
    .x_i   (mm_x),
    .y_i   (mm_y),
    .c_i   (mm_c),
    .done  (mm_done),
    .res   (mm_res)
  );

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign hit_w   = full_r && (win_hash_r == pat_hash_r);
  assign match_w = hit_w && all_eq;
  assign found_w = found_r || match_w;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_PREP;
      end
      S_PREP: begin
        if (item_r.req_type == REQ_PATTERN) begin
          state_nxt = S_PAT;
        end else if (pat_len_r == '0) begin
          state_nxt = S_CMP;
        end else if (fill_r == pat_len_r) begin
          state_nxt = S_TXT_SUB;
        end else begin
          state_nxt = S_TXT_HASH;
        end
      end
      S_PAT: begin
        if (pat_len_r < LEN_W'(PATTERN_MAX)) begin
          state_nxt = (pat_len_r != '0) ? S_PAT_LEAD : S_PAT_HASH;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PAT_LEAD: begin
        if (mm_done) state_nxt = S_PAT_HASH;
      end
      S_PAT_HASH: begin
        if (mm_done) state_nxt = S_IDLE;
      end
      S_TXT_SUB: begin
        if (mm_done) state_nxt = S_TXT_HASH;
      end
      S_TXT_HASH: begin
        if (mm_done) state_nxt = S_CMP;
      end
      S_CMP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath control
  // --------------------------------------------------------------------------
  always_comb begin
    item_nxt      = item_r;
    pat_len_nxt   = pat_len_r;
    pat_done_nxt  = pat_done_r;
    pat_hash_nxt  = pat_hash_r;
    lead_nxt      = lead_r;
    win_hash_nxt  = win_hash_r;
    text_cnt_nxt  = text_cnt_r;
    found_nxt     = found_r;
    fill_nxt      = fill_r;
    full_nxt      = full_r;
    end_nxt       = end_r;
    v_nxt         = v_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    mm_start      = 1'b0;
    mm_x          = '0;
    mm_y          = '0;
    mm_c          = '0;
    cell_ctrl     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) item_nxt = in_data;
      end
      S_PREP: begin
        if (item_r.req_type == REQ_PATTERN) begin
          // a pattern word after a closed pattern starts over
          if (pat_done_r) begin
            pat_len_nxt         = '0;
            pat_hash_nxt        = '0;
            lead_nxt            = HASH_W'(1);
            pat_done_nxt        = 1'b0;
            cell_ctrl.pat_clear = 1'b1;
            win_hash_nxt        = '0;
            text_cnt_nxt        = '0;
            found_nxt           = 1'b0;
            fill_nxt            = '0;
          end
        end else begin
          pat_done_nxt = 1'b1;
          end_nxt      = text_cnt_r;
          if (text_cnt_r != '1) text_cnt_nxt = text_cnt_r + POS_W'(1);
          full_nxt = 1'b0;
          if (pat_len_r != '0) begin
            v_nxt               = sym_value(item_r.symbol);
            cell_ctrl.win_shift = 1'b1;
            mm_start            = 1'b1;
            if (fill_r == pat_len_r) begin
              // remove the departing symbol: old * 37^(L-1)
              full_nxt = 1'b1;
              mm_x     = 21'(lead_r);
              mm_y     = sym_value(tail_any);
            end else begin
              fill_nxt = fill_r + LEN_W'(1);
              full_nxt = ((fill_r + LEN_W'(1)) == pat_len_r);
              mm_x     = 21'(win_hash_r);
              mm_y     = HASH_BASE;
              mm_c     = sym_value(item_r.symbol);
            end
          end
        end
      end
      S_PAT: begin
        if (pat_len_r < LEN_W'(PATTERN_MAX)) begin
          cell_ctrl.pat_shift = 1'b1;
          pat_len_nxt         = pat_len_r + LEN_W'(1);
          mm_start            = 1'b1;
          mm_y                = HASH_BASE;
          if (pat_len_r != '0) begin
            mm_x = 21'(lead_r);
          end else begin
            mm_x = 21'(pat_hash_r);
            mm_c = sym_value(item_r.symbol);
          end
        end else if (item_r.last) begin
          pat_done_nxt = 1'b1;
        end
      end
      S_PAT_LEAD: begin
        if (mm_done) begin
          lead_nxt = mm_res;
          mm_start = 1'b1;
          mm_x     = 21'(pat_hash_r);
          mm_y     = HASH_BASE;
          mm_c     = sym_value(item_r.symbol);
        end
      end
      S_PAT_HASH: begin
        if (mm_done) begin
          pat_hash_nxt = mm_res;
          if (item_r.last) pat_done_nxt = 1'b1;
        end
      end
      S_TXT_SUB: begin
        if (mm_done) begin
          // (h + M - sub) stays below 2M; mulmod reduces it along the way
          mm_start = 1'b1;
          mm_x     = 21'(win_hash_r) + 21'(HASH_MOD) - 21'(mm_res);
          mm_y     = HASH_BASE;
          mm_c     = v_r;
        end
      end
      S_TXT_HASH: begin
        if (mm_done) win_hash_nxt = mm_res;
      end
      S_CMP: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.window_end  = end_r;
          out_nxt.window_full = full_r;
          out_nxt.hash_hit    = hit_w;
          out_nxt.match       = match_w;
          out_nxt.found       = found_w;
          out_nxt.done_res    = item_r.last;
          found_nxt           = found_w;
          if (item_r.last) begin
            // end of text: pattern stays, text state starts over
            win_hash_nxt = '0;
            text_cnt_nxt = '0;
            found_nxt    = 1'b0;
            fill_nxt     = '0;
          end
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && out_stall;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pat_len_r   <= '0;
      pat_done_r  <= 1'b0;
      pat_hash_r  <= '0;
      lead_r      <= HASH_W'(1);
      win_hash_r  <= '0;
      text_cnt_r  <= '0;
      found_r     <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pat_len_r   <= pat_len_nxt;
      pat_done_r  <= pat_done_nxt;
      pat_hash_r  <= pat_hash_nxt;
      lead_r      <= lead_nxt;
      win_hash_r  <= win_hash_nxt;
      text_cnt_r  <= text_cnt_nxt;
      found_r     <= found_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    full_r <= full_nxt;
    end_r  <= end_nxt;
    v_r    <= v_nxt;
    out_r  <= out_nxt;
  end

endmodule

FILE: rtl/core/rhpm_cell.sv
// ----------------------------------------------------------------------------
// rhpm_cell
// One position of the pattern/window chain: holds a pattern byte, its valid
// bit and a window byte, shifts them on to the next cell and compares them.
// ----------------------------------------------------------------------------
module rhpm_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rhpm_pkg::rhpm_cell_ctrl_t ctrl,
  input  logic [7:0]                pat_byte_in,
  input  logic                      pat_v_in,
  input  logic [7:0]                win_byte_in,
  input  logic                      next_pat_v,
  output logic [7:0]                pat_byte_o,
  output logic                      pat_v_o,
  output logic [7:0]                win_byte_o,
  output logic [7:0]                tail_byte,
  output logic                      eq
);
  import rhpm_pkg::*;

  logic [SYM_W-1:0] pat_byte_r;
  logic [SYM_W-1:0] win_byte_r;
  logic             pat_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.pat_clear) begin
      pat_v_r <= 1'b0;
    end else if (ctrl.pat_shift) begin
      pat_v_r <= pat_v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pat_shift) begin
      pat_byte_r <= pat_byte_in;
    end
    if (ctrl.win_shift) begin
      win_byte_r <= win_byte_in;
    end
  end

  assign pat_byte_o = pat_byte_r;
  assign pat_v_o    = pat_v_r;
  assign win_byte_o = win_byte_r;

  // last loaded position holds the oldest window byte
  assign tail_byte = (pat_v_r && !next_pat_v) ? win_byte_r : '0;
  assign eq        = !pat_v_r || (pat_byte_r == win_byte_r);

endmodule

FILE: rtl/core/rhpm_mulmod.sv
// ----------------------------------------------------------------------------
// rhpm_mulmod
// Four-stage (x * y + c) mod 1e6+3 with x < 2^21, y and c below 2^8.
// Reduction folds the bits above 2^20 back in with 2^20 mod M.
// ----------------------------------------------------------------------------
module rhpm_mulmod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [20:0] x_i,
  input  logic [7:0]  y_i,
  input  logic [7:0]  c_i,
  output logic        done,
  output logic [19:0] res
);
  import rhpm_pkg::*;

  logic [3:0]        vld_r;
  logic [29:0]       p_r;
  logic [25:0]       f1_r;
  logic [21:0]       f2_r;
  logic [HASH_W-1:0] res_r;
  logic [20:0]       f3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], start};
    end
  end

  assign f3 = 21'(f2_r[21:HASH_W]) * 21'(FOLD_K) + 21'(f2_r[HASH_W-1:0]);

  always_ff @(posedge clk) begin
    p_r   <= 30'(x_i) * 30'(y_i) + 30'(c_i);
    f1_r  <= 26'(p_r[29:HASH_W]) * 26'(FOLD_K) + 26'(p_r[HASH_W-1:0]);
    f2_r  <= 22'(f1_r[25:HASH_W]) * 22'(FOLD_K) + 22'(f1_r[HASH_W-1:0]);
    // f3 < 2M, one subtract finishes it
    res_r <= (f3 >= 21'(HASH_MOD)) ? HASH_W'(f3 - 21'(HASH_MOD)) : HASH_W'(f3);
  end

  assign done = vld_r[3];
  assign res  = res_r;

endmodule

FILE: verif/tb_rolling_hash_pattern_matcher.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// tb_rolling_hash_pattern_matcher
// Self-checking bench for the streaming Rabin-Karp matcher. A shadow model
// predicts one report per accepted text word, and each report the block
// returns is compared field by field with the oldest prediction. The tests
// run in turn: text on an empty pattern, hand-picked corner cases, pattern
// overflow, a long receiver hold-off, and random pattern/text streams.
// Random gaps are applied on both sides.
// ----------------------------------------------------------------------------
module tb_rolling_hash_pattern_matcher;

  localparam int unsigned SIG_MOD      = 1000003;  // hash modulus
  localparam int unsigned SIG_BASE     = 37;       // polynomial base
  localparam int          PAT_DEPTH    = rhpm_pkg::PATTERN_MAX;
  localparam int          QUIET_CYCLES = 16;       // > worst word occupancy
  localparam int          HOLD_CYCLES  = 400;      // long receiver hold-off
  localparam int          RANDOM_WORDS = 2000;
  localparam int          EMPTY_WORDS  = 40;       // text words on an empty pattern

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  rhpm_pkg::rhpm_in_t  in_data;
  logic                out_valid;
  logic                out_stall;
  rhpm_pkg::rhpm_out_t out_data;

  rolling_hash_pattern_matcher dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Reports predicted but not yet returned, oldest first.
  rhpm_pkg::rhpm_out_t reports_due[$];
  int fail_count;
  int words_sent;

  // Idle control. The steady flags switch random gaps off on that side;
  // rx_hold asks the receiver for one long stall, counted down over there.
  bit tx_steady;
  bit rx_steady;
  int rx_hold;

  // --------------------------------------------------------------------------
  // Shadow of the matcher state
  // --------------------------------------------------------------------------
  logic [7:0]  pat_bytes [PAT_DEPTH];
  logic [7:0]  win_bytes [PAT_DEPTH];
  logic [6:0]  pat_len;
  logic        pat_closed;
  logic [19:0] pat_sig;     // hash of the pattern
  logic [19:0] lead_pow;    // 37^(len-1) mod M, weight of the oldest window byte
  logic [19:0] win_sig;     // rolling hash of the window
  logic [15:0] txt_pos;     // saturating text position
  logic        seen_match;  // sticky found
  logic [6:0]  win_cnt;     // bytes in the window so far
  logic [6:0]  win_wr;      // next window slot to overwrite (oldest byte)

  // clock: 10 ns period
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Letters weigh 0..25, digits 26..35; any other byte weighs its own code,
  // which is already below the modulus.
  function automatic logic [19:0] sym_weight(input logic [7:0] b);
    if (b >= rhpm_pkg::CHR_A && b <= rhpm_pkg::CHR_Z) return 20'(b - rhpm_pkg::CHR_A);
    if (b >= rhpm_pkg::CHR_0 && b <= rhpm_pkg::CHR_9)
      return 20'(b - rhpm_pkg::CHR_0) + 20'(rhpm_pkg::DIGIT_BASE);
    return 20'(b);
  endfunction

  function automatic logic [19:0] mul_mod(input logic [19:0] a, input logic [19:0] b);
    return 20'((40'(a) * 40'(b)) % SIG_MOD);
  endfunction

  function automatic logic [19:0] sig_push(input logic [19:0] h, input logic [19:0] v);
    return 20'((40'(h) * SIG_BASE + 40'(v)) % SIG_MOD);
  endfunction

  function automatic void drop_text();
    win_sig    = '0;
    txt_pos    = '0;
    seen_match = 1'b0;
    win_cnt    = '0;
    win_wr     = '0;
  endfunction

  function automatic void shadow_reset();
    pat_len    = '0;
    pat_closed = 1'b0;
    pat_sig    = '0;
    lead_pow   = 20'd1;
    drop_text();
  endfunction

  // Advance the shadow by one accepted word; a text word queues its report.
  function automatic void track_word(input rhpm_pkg::rhpm_in_t w);
    rhpm_pkg::rhpm_out_t r;
    logic [19:0] old_part;
    logic [6:0]  idx;
    logic        full;
    logic        hit;
    logic        same;
    r    = '0;
    full = 1'b0;
    hit  = 1'b0;
    same = 1'b0;
    if (w.req_type == rhpm_pkg::REQ_PATTERN) begin
      // a pattern word after a closed pattern starts over and drops the text
      if (pat_closed) begin
        pat_len    = '0;
        pat_sig    = '0;
        lead_pow   = 20'd1;
        pat_closed = 1'b0;
        drop_text();
      end
      // words past the store depth are dropped, but their last mark still counts
      if (pat_len < PAT_DEPTH) begin
        if (pat_len != 0) lead_pow = mul_mod(lead_pow, 20'(SIG_BASE));
        pat_bytes[pat_len] = w.symbol;
        pat_sig = sig_push(pat_sig, sym_weight(w.symbol));
        pat_len++;
      end
      if (w.last) pat_closed = 1'b1;
      return;
    end

    // text closes the pattern as it stands
    pat_closed   = 1'b1;
    r.window_end = txt_pos;
    if (txt_pos != 16'hFFFF) txt_pos++;

    // an empty pattern never fills the window
    if (pat_len != 0) begin
      if (win_cnt == pat_len) begin
        old_part = mul_mod(sym_weight(win_bytes[win_wr]), lead_pow);
        win_sig  = 20'((40'(win_sig) + SIG_MOD - 40'(old_part)) % SIG_MOD);
      end else begin
        win_cnt++;
      end
      win_sig = sig_push(win_sig, sym_weight(w.symbol));
      win_bytes[win_wr] = w.symbol;
      win_wr = (win_wr + 7'd1 >= pat_len) ? 7'd0 : win_wr + 7'd1;

      full = (win_cnt == pat_len);
      hit  = full && (win_sig == pat_sig);
      // hash hit: confirm byte for byte, oldest window byte first
      if (hit) begin
        same = 1'b1;
        idx  = win_wr;
        for (int k = 0; k < pat_len; k++) begin
          if (win_bytes[idx] != pat_bytes[k]) same = 1'b0;
          idx = (idx + 7'd1 >= pat_len) ? 7'd0 : idx + 7'd1;
        end
      end
      if (same) seen_match = 1'b1;
    end

    r.window_full = full;
    r.hash_hit    = hit;
    r.match       = same;
    r.found       = seen_match;
    r.done_res    = w.last;
    reports_due.push_back(r);

    // end of text: text state cleared, pattern kept
    if (w.last) drop_text();
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Symbol pools: 0 tiny alphabet, 1 letters and digits, 2 any byte,
  // 3 letters and digits mixed with raw bytes of the same weight.
  function automatic logic [7:0] pick_sym(input int pool);
    case (pool)
      0: return rhpm_pkg::CHR_A + 8'($urandom_range(0, 1));
      1: begin
        if ($urandom_range(0, 2) != 0) return rhpm_pkg::CHR_A + 8'($urandom_range(0, 3));
        return rhpm_pkg::CHR_0 + 8'($urandom_range(0, 2));
      end
      2: return 8'($urandom_range(0, 255));
      default: begin
        case ($urandom_range(0, 3))
          0: return rhpm_pkg::CHR_A + 8'($urandom_range(0, 1));
          1: return 8'($urandom_range(0, 1));
          2: return rhpm_pkg::CHR_0;
          default: return rhpm_pkg::DIGIT_BASE;
        endcase
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender: offer one word, hold it until accepted, then maybe idle.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic req, input logic [7:0] sym, input logic fin);
    rhpm_pkg::rhpm_in_t w;
    int gap;
    w.req_type = req;
    w.symbol   = sym;
    w.last     = fin;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    track_word(w);
    words_sent++;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender pauses until every predicted report is back, then lets the
  // block finish any pattern word still in flight.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request.
  // --------------------------------------------------------------------------
  initial begin
    int rx_wait;
    rx_wait   = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else if (rx_wait > 0) begin
        out_stall <= 1'b1;
        rx_wait--;
      end else begin
        out_stall <= 1'b0;
        if (!rx_steady) rx_wait = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: every accepted report against the oldest prediction
  // --------------------------------------------------------------------------
  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    rhpm_pkg::rhpm_out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (reports_due.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected report: expected none, actual %0h", $time, out_data);
      end else begin
        want = reports_due.pop_front();
        check_field("window_end", want.window_end, out_data.window_end);
        check_field("window_full", want.window_full, out_data.window_full);
        check_field("hash_hit", want.hash_hit, out_data.hash_hit);
        check_field("match", want.match, out_data.match);
        check_field("found", want.found, out_data.found);
        check_field("done_res", want.done_res, out_data.done_res);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Only right after reset is the pattern empty: the window never fills, so
  // no hit, no match and found stays clear.
  task automatic test_empty_pattern();
    for (int n = 0; n < EMPTY_WORDS; n++)
      send_word(rhpm_pkg::REQ_TEXT, 8'($urandom_range(0, 255)), n == EMPTY_WORDS - 1);
    wait_quiet();
  endtask

  task automatic test_directed_cases();
    // pattern "ab": two matches in a row, found stays set, end of text clears
    send_word(rhpm_pkg::REQ_PATTERN, "a", 1'b0);
    send_word(rhpm_pkg::REQ_PATTERN, "b", 1'b1);
    send_word(rhpm_pkg::REQ_TEXT, "a", 1'b0);
    send_word(rhpm_pkg::REQ_TEXT, "b", 1'b0);
    send_word(rhpm_pkg::REQ_TEXT, "a", 1'b0);
    send_word(rhpm_pkg::REQ_TEXT, "b", 1'b0);
    send_word(rhpm_pkg::REQ_TEXT, "z", 1'b1);
    // pattern kept across texts
    send_word(rhpm_pkg::REQ_TEXT, "a", 1'b0);
    send_word(rhpm_pkg::REQ_TEXT, "b", 1'b1);
    // pattern "a": byte 0x00 weighs the same, so a hash hit without a match
    send_word(rhpm_pkg::REQ_PATTERN, "a", 1'b1);
    send_word(rhpm_pkg::REQ_TEXT, 8'h00, 1'b0);
    send_word(rhpm_pkg::REQ_TEXT, "a", 1'b0);
    send_word(rhpm_pkg::REQ_TEXT, 8'hFF, 1'b1);
    // pattern left open; the first text word closes it
    send_word(rhpm_pkg::REQ_PATTERN, "9", 1'b0);
    send_word(rhpm_pkg::REQ_TEXT, "9", 1'b0);
    send_word(rhpm_pkg::REQ_TEXT, 8'h23, 1'b0);  // weight 35, same as '9'
    // pattern word in mid-text: fresh pattern, text restarts at position 0
    send_word(rhpm_pkg::REQ_PATTERN, 8'hFF, 1'b0);
    send_word(rhpm_pkg::REQ_PATTERN, "0", 1'b1);
    send_word(rhpm_pkg::REQ_TEXT, 8'hFF, 1'b0);
    send_word(rhpm_pkg::REQ_TEXT, "0", 1'b1);
    wait_quiet();
  endtask

  // 70 pattern words: the last six are dropped, their last mark still closes
  // the pattern; the text then carries the 64 stored bytes.
  task automatic test_pattern_overflow();
    logic [7:0] pat [$];
    for (int k = 0; k < 70; k++) pat.push_back(rhpm_pkg::CHR_A + 8'($urandom_range(0, 2)));
    for (int k = 0; k < 70; k++) send_word(rhpm_pkg::REQ_PATTERN, pat[k], k == 69);
    send_word(rhpm_pkg::REQ_TEXT, "x", 1'b0);
    for (int k = 0; k < PAT_DEPTH; k++)
      send_word(rhpm_pkg::REQ_TEXT, pat[k], k == PAT_DEPTH - 1);
    wait_quiet();
  endtask

  // Receiver holds off while the sender keeps offering text back to back,
  // so the block fills up and stalls its input.
  task automatic test_output_backpressure();
    send_word(rhpm_pkg::REQ_PATTERN, "a", 1'b0);
    send_word(rhpm_pkg::REQ_PATTERN, "b", 1'b1);
    rx_hold   = HOLD_CYCLES;
    tx_steady = 1'b1;
    for (int k = 0; k < 48; k++)
      send_word(rhpm_pkg::REQ_TEXT, (k % 2 == 0) ? 8'("a") : 8'("b"), k == 47);
    tx_steady = 1'b0;
    wait_quiet();
  endtask

  // Mostly well-formed streams: a pattern, then text with planted copies
  // (some with one byte changed). Now and then the last mark is left off,
  // the pattern is reused, or a random word is thrown in.
  task automatic test_random_streams();
    logic [7:0] pat [$];
    logic [7:0] txt [$];
    int first;
    int pool;
    int plen;
    int tlen;
    int r;
    first = words_sent;
    while (words_sent - first < RANDOM_WORDS) begin
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      pool = $urandom_range(0, 3);

      if (pat.size() == 0 || $urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, 99);
        if (r < 80)      plen = $urandom_range(1, 6);
        else if (r < 95) plen = $urandom_range(7, 20);
        else if (r < 99) plen = $urandom_range(21, PAT_DEPTH);
        else             plen = $urandom_range(PAT_DEPTH + 1, PAT_DEPTH + 6);
        pat.delete();
        for (int k = 0; k < plen; k++) pat.push_back(pick_sym(pool));
        for (int k = 0; k < plen; k++)
          send_word(rhpm_pkg::REQ_PATTERN, pat[k],
                    k == plen - 1 && $urandom_range(0, 9) != 0);
      end

      tlen = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
      txt.delete();
      while (txt.size() < tlen) begin
        if ($urandom_range(0, 3) == 0) begin
          foreach (pat[k]) txt.push_back(pat[k]);
          if ($urandom_range(0, 2) == 0)
            txt[txt.size() - 1 - $urandom_range(0, pat.size() - 1)] = pick_sym(pool);
        end else begin
          txt.push_back(pick_sym(pool));
        end
      end
      for (int k = 0; k < txt.size(); k++)
        send_word(rhpm_pkg::REQ_TEXT, txt[k], k == txt.size() - 1 && $urandom_range(0, 9) != 0);

      if ($urandom_range(0, 19) == 0)
        send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      if ($urandom_range(0, 19) == 0) wait_quiet();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    tx_steady  = 1'b0;
    rx_steady  = 1'b0;
    rx_hold    = 0;
    fail_count = 0;
    words_sent = 0;
    shadow_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_pattern();
    test_directed_cases();
    test_pattern_overflow();
    test_output_backpressure();
    test_random_streams();
    wait_quiet();

    if (fail_count == 0) begin
      $display("tb_rolling_hash_pattern_matcher: PASS");
    end else begin
      $display("tb_rolling_hash_pattern_matcher: FAIL");
    end
    $finish;
  end

  // Watchdog: a correct run finishes well within this limit, even with every
  // gap and stall at its longest; a run still going when it expires fails.
  initial begin
    #30_000_000;
    $display("tb_rolling_hash_pattern_matcher: FAIL");
    $finish;
  end

endmodule
